### sv/hwcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hot water charge controller package
// Shared types, register indexes, reset values and the weekday remap table.
// ----------------------------------------------------------------------------
package hwcc_pkg;

	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 3;

	// Source must be this much warmer than the tank, tenths of a degree
	localparam logic signed [13:0] SOURCE_MARGIN = 14'sd50;
	localparam logic [15:0]        ELAPSED_MAX   = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_ENABLED    = 3'd0,
		REG_TARGET_TEMP      = 3'd1,
		REG_HYSTERESIS_BAND  = 3'd2,
		REG_LEGIO_ON         = 3'd3,
		REG_LEGIO_DAY        = 3'd4,
		REG_LEGIO_START_HOUR = 3'd5,
		REG_LEGIO_TARGET     = 3'd6,
		REG_HOLIDAY_END      = 3'd7
	} cfg_reg_t;

	localparam logic signed [11:0] TARGET_TEMP_RST      = 12'sd500;
	localparam logic [8:0]         HYSTERESIS_BAND_RST  = 9'd50;
	localparam logic [4:0]         LEGIO_START_HOUR_RST = 5'd2;
	localparam logic signed [11:0] LEGIO_TARGET_RST     = 12'sd650;

	typedef struct packed {
		logic               block_enabled;
		logic signed [11:0] target_temp;
		logic [8:0]         hysteresis_band;
		logic               legio_on;
		logic [2:0]         legio_day;
		logic [4:0]         legio_start_hour;
		logic signed [11:0] legio_target;
		logic [31:0]        holiday_end;
	} cfg_t;

	typedef struct packed {
		logic signed [11:0] tank_temp;
		logic               tank_valid;
		logic signed [11:0] source_temp;
		logic               source_valid;
		logic [2:0]         week_day;
		logic [4:0]         hour_of_day;
		logic [8:0]         year_day;
		logic [31:0]        epoch_now;
		logic [7:0]         tick_seconds;
		logic               schedule_allows;
	} item_t;

	typedef struct packed {
		logic pump_on;
		logic legio_running;
		logic sensor_fault;
		logic legio_fail;
	} result_t;

	// Sunday-based weekday to Monday-based weekday; code 7 lands on Sunday
	function automatic logic [2:0] monday_day(input logic [2:0] wday);
		logic [2:0] d;
		case (wday)
			3'd0:    d = 3'd6;
			3'd1:    d = 3'd0;
			3'd2:    d = 3'd1;
			3'd3:    d = 3'd2;
			3'd4:    d = 3'd3;
			3'd5:    d = 3'd4;
			3'd6:    d = 3'd5;
			default: d = 3'd6;
		endcase
		return d;
	endfunction

endpackage

### sv/hwcc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hot water charge controller configuration registers
// Write-only register bank; each write updates one field of the setup.
// ----------------------------------------------------------------------------
module hwcc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [hwcc_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [hwcc_pkg::CFG_DATA_W-1:0]     wr_data,
	output hwcc_pkg::cfg_t                      cfg
);

	hwcc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_enabled    <= 1'b0;
			cfg_q.target_temp      <= hwcc_pkg::TARGET_TEMP_RST;
			cfg_q.hysteresis_band  <= hwcc_pkg::HYSTERESIS_BAND_RST;
			cfg_q.legio_on         <= 1'b0;
			cfg_q.legio_day        <= 3'd0;
			cfg_q.legio_start_hour <= hwcc_pkg::LEGIO_START_HOUR_RST;
			cfg_q.legio_target     <= hwcc_pkg::LEGIO_TARGET_RST;
			cfg_q.holiday_end      <= 32'd0;
		end else if (wr_en) begin
			case (wr_index)
				hwcc_pkg::REG_BLOCK_ENABLED:    cfg_q.block_enabled    <= wr_data[0];
				hwcc_pkg::REG_TARGET_TEMP:      cfg_q.target_temp      <= wr_data[11:0];
				hwcc_pkg::REG_HYSTERESIS_BAND:  cfg_q.hysteresis_band  <= wr_data[8:0];
				hwcc_pkg::REG_LEGIO_ON:         cfg_q.legio_on         <= wr_data[0];
				hwcc_pkg::REG_LEGIO_DAY:        cfg_q.legio_day        <= wr_data[2:0];
				hwcc_pkg::REG_LEGIO_START_HOUR: cfg_q.legio_start_hour <= wr_data[4:0];
				hwcc_pkg::REG_LEGIO_TARGET:     cfg_q.legio_target     <= wr_data[11:0];
				hwcc_pkg::REG_HOLIDAY_END:      cfg_q.holiday_end      <= wr_data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/hwcc_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hot water charge controller decision stage
// Holds the controller state and forms one result per tick from the staged
// item; the state advances only when that result is taken.
// ----------------------------------------------------------------------------
module hwcc_decide #(
	parameter int unsigned LEGIO_LIMIT_SECONDS = 10800
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  hwcc_pkg::cfg_t       cfg,
	input  hwcc_pkg::item_t      item,
	output hwcc_pkg::result_t    result
);

	localparam logic [15:0] LIMIT = 16'(LEGIO_LIMIT_SECONDS);

	logic        charging_q;
	logic        legio_active_q;
	logic [15:0] legio_elapsed_q;
	logic [8:0]  last_day_q;
	logic        day_valid_q;
	logic        sensor_alarm_q;
	logic        legio_alarm_q;

	logic        charging_d;
	logic        legio_active_d;
	logic [15:0] legio_elapsed_d;
	logic [8:0]  last_day_d;
	logic        day_valid_d;
	logic        sensor_alarm_d;
	logic        legio_alarm_d;
	logic        pump_d;

	logic               holiday;
	logic               trigger;
	logic               active_mid;
	logic [15:0]        elapsed_base;
	logic [16:0]        elapsed_sum;
	logic [15:0]        elapsed_sat;
	logic signed [11:0] set_pt;
	logic signed [13:0] set_x;
	logic signed [13:0] set_lo;
	logic signed [13:0] tank_x;
	logic signed [13:0] src_x;
	logic               want;

	always_comb begin
		holiday = (cfg.holiday_end != 32'd0) && (item.epoch_now < cfg.holiday_end);
		trigger = cfg.legio_on && !legio_active_q
			&& (hwcc_pkg::monday_day(item.week_day) == cfg.legio_day)
			&& (item.hour_of_day == cfg.legio_start_hour)
			&& (!day_valid_q || (last_day_q != item.year_day));
		active_mid   = legio_active_q || trigger;
		elapsed_base = trigger ? 16'd0 : legio_elapsed_q;
		elapsed_sum  = {1'b0, elapsed_base} + {9'd0, item.tick_seconds};
		elapsed_sat  = elapsed_sum[16] ? hwcc_pkg::ELAPSED_MAX : elapsed_sum[15:0];

		tank_x = {{2{item.tank_temp[11]}}, item.tank_temp};
		src_x  = {{2{item.source_temp[11]}}, item.source_temp};

		// hold by default
		charging_d      = charging_q;
		legio_active_d  = legio_active_q;
		legio_elapsed_d = legio_elapsed_q;
		last_day_d      = last_day_q;
		day_valid_d     = day_valid_q;
		sensor_alarm_d  = sensor_alarm_q;
		legio_alarm_d   = legio_alarm_q;
		pump_d          = 1'b0;
		set_pt          = cfg.target_temp;
		set_x           = '0;
		set_lo          = '0;
		want            = 1'b0;

		if (cfg.block_enabled) begin
			if (!item.tank_valid) begin
				sensor_alarm_d = 1'b1;
				charging_d     = 1'b0;
			end else begin
				sensor_alarm_d = 1'b0;
				if (trigger) begin
					last_day_d  = item.year_day;
					day_valid_d = 1'b1;
				end
				legio_active_d = active_mid;
				if (active_mid) begin
					legio_elapsed_d = elapsed_sat;
					if (item.tank_temp >= cfg.legio_target) begin
						legio_active_d = 1'b0;
						legio_alarm_d  = 1'b0;
					end else if (elapsed_sat > LIMIT) begin
						legio_active_d = 1'b0;
						legio_alarm_d  = 1'b1;
					end
				end

				set_pt = legio_active_d ? cfg.legio_target : cfg.target_temp;
				set_x  = {{2{set_pt[11]}}, set_pt};
				set_lo = set_x - $signed({5'd0, cfg.hysteresis_band});

				want = charging_q;
				if (tank_x < set_lo)
					want = 1'b1;
				if (tank_x >= set_x)
					want = 1'b0;
				if (!item.schedule_allows && !legio_active_d)
					want = 1'b0;
				if (holiday && !legio_active_d)
					want = 1'b0;
				if (item.source_valid && (src_x < tank_x + hwcc_pkg::SOURCE_MARGIN))
					want = 1'b0;

				charging_d = want;
				pump_d     = want;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charging_q      <= 1'b0;
			legio_active_q  <= 1'b0;
			legio_elapsed_q <= 16'd0;
			last_day_q      <= 9'd0;
			day_valid_q     <= 1'b0;
			sensor_alarm_q  <= 1'b0;
			legio_alarm_q   <= 1'b0;
		end else if (take) begin
			charging_q      <= charging_d;
			legio_active_q  <= legio_active_d;
			legio_elapsed_q <= legio_elapsed_d;
			last_day_q      <= last_day_d;
			day_valid_q     <= day_valid_d;
			sensor_alarm_q  <= sensor_alarm_d;
			legio_alarm_q   <= legio_alarm_d;
		end
	end

	assign result.pump_on       = pump_d;
	assign result.legio_running = legio_active_d;
	assign result.sensor_fault  = sensor_alarm_d;
	assign result.legio_fail    = legio_alarm_d;

endmodule

### sv/hot_water_charge_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hot water charge controller
// Tank charge pump control with two-point hysteresis and a weekly legionella
// heat-up.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall) carries one tick: tank and source
//    readings, calendar time, elapsed seconds and the schedule flag.
//  - Output channel (out_valid / out_stall) returns one result per tick:
//    pump_on, legio_running, sensor_fault, legio_fail.
//  - Configuration is a write-only port (wr_en, wr_index, wr_data); write it
//    only while no tick is in flight.
//  - A tick transferred in is loaded into the input register and, when it
//    advances, into the result register that drives out_valid.
//  - Throughput is one tick per cycle while out_stall is low, set by
//    the single decision stage, updating controller state per loaded result.
//  - While out_stall holds a result, the staged tick waits and in_stall rises
//    once the input register is also full; nothing is dropped.
//  - Reset clears the channels and all controller state and loads the
//    register defaults (block disabled).
// ----------------------------------------------------------------------------
module hot_water_charge_controller #(
	parameter int unsigned LEGIO_LIMIT_SECONDS = 10800
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              wr_en,
	input  logic [hwcc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [hwcc_pkg::CFG_DATA_W-1:0]   wr_data,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [11:0]                tank_temp,
	input  logic                              tank_valid,
	input  logic signed [11:0]                source_temp,
	input  logic                              source_valid,
	input  logic [2:0]                        week_day,
	input  logic [4:0]                        hour_of_day,
	input  logic [8:0]                        year_day,
	input  logic [31:0]                       epoch_now,
	input  logic [7:0]                        tick_seconds,
	input  logic                              schedule_allows,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              pump_on,
	output logic                              legio_running,
	output logic                              sensor_fault,
	output logic                              legio_fail
);

	hwcc_pkg::cfg_t    cfg;
	hwcc_pkg::item_t   item_s1;
	logic              valid_s1;
	hwcc_pkg::result_t result;
	hwcc_pkg::result_t res_q;
	logic              out_valid_q;
	logic              advance;
	logic              in_take;

	hwcc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Move the staged tick on when the result register is empty or drains
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.tank_temp       <= tank_temp;
			item_s1.tank_valid      <= tank_valid;
			item_s1.source_temp     <= source_temp;
			item_s1.source_valid    <= source_valid;
			item_s1.week_day        <= week_day;
			item_s1.hour_of_day     <= hour_of_day;
			item_s1.year_day        <= year_day;
			item_s1.epoch_now       <= epoch_now;
			item_s1.tick_seconds    <= tick_seconds;
			item_s1.schedule_allows <= schedule_allows;
		end
	end

	hwcc_decide #(
		.LEGIO_LIMIT_SECONDS (LEGIO_LIMIT_SECONDS)
	) u_decide (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign pump_on       = res_q.pump_on;
	assign legio_running = res_q.legio_running;
	assign sensor_fault  = res_q.sensor_fault;
	assign legio_fail    = res_q.legio_fail;

`ifndef SYNTHESIS
	// A running pump never goes with a missing tank sensor
	a_pump_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pump_on |-> !sensor_fault)
		else $error("pump on while tank sensor alarm is set");

	// Back-pressure only when a tick is actually staged
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	// A staged tick that moves on must show up as a result
	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result lost after stage transfer");
`endif

endmodule

### test/hot_water_charge_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hot water charge controller testbench
// Drives ticks through the valid/stall channels and predicts every result in
// a scoreboard: hysteresis charging, schedule, holiday and source gating, the
// sensor fault and the weekly legionella heat-up with its timeout. A directed
// run comes first, then random ticks in segments (heating ramps, cold tanks
// that time out, noise) under several register settings and idle profiles.
// ----------------------------------------------------------------------------
module hot_water_charge_controller_test;

	localparam int unsigned HEATUP_LIMIT = 10800;

	class charge_scoreboard;
		hwcc_pkg::cfg_t    cfg;
		bit                charging;
		bit                heatup_active;
		int unsigned       heatup_secs;
		logic [8:0]        last_heatup_day;
		bit                heatup_day_seen;
		bit                fault_latched;
		bit                timeout_latched;
		hwcc_pkg::result_t expected_results[$];
		int                errors;

		function new();
			cfg                  = '0;
			cfg.target_temp      = hwcc_pkg::TARGET_TEMP_RST;
			cfg.hysteresis_band  = hwcc_pkg::HYSTERESIS_BAND_RST;
			cfg.legio_start_hour = hwcc_pkg::LEGIO_START_HOUR_RST;
			cfg.legio_target     = hwcc_pkg::LEGIO_TARGET_RST;
			charging             = 0;
			heatup_active        = 0;
			heatup_secs          = 0;
			last_heatup_day      = '0;
			heatup_day_seen      = 0;
			fault_latched        = 0;
			timeout_latched      = 0;
			errors               = 0;
		endfunction

		function void update_reg(hwcc_pkg::cfg_reg_t idx, logic [31:0] d);
			case (idx)
				hwcc_pkg::REG_BLOCK_ENABLED:    cfg.block_enabled    = d[0];
				hwcc_pkg::REG_TARGET_TEMP:      cfg.target_temp      = d[11:0];
				hwcc_pkg::REG_HYSTERESIS_BAND:  cfg.hysteresis_band  = d[8:0];
				hwcc_pkg::REG_LEGIO_ON:         cfg.legio_on         = d[0];
				hwcc_pkg::REG_LEGIO_DAY:        cfg.legio_day        = d[2:0];
				hwcc_pkg::REG_LEGIO_START_HOUR: cfg.legio_start_hour = d[4:0];
				hwcc_pkg::REG_LEGIO_TARGET:     cfg.legio_target     = d[11:0];
				hwcc_pkg::REG_HOLIDAY_END:      cfg.holiday_end      = d;
				default: ;
			endcase
		endfunction

		function hwcc_pkg::result_t predict_charge(hwcc_pkg::item_t t);
			hwcc_pkg::result_t r;
			int                tank, src, setp, mday;
			int unsigned       secs;
			bit                want, holiday;
			tank = $signed(t.tank_temp);
			src  = $signed(t.source_temp);
			want = 0;
			if (cfg.block_enabled) begin
				if (!t.tank_valid) begin
					fault_latched = 1;
					charging      = 0;
				end else begin
					fault_latched = 0;
					holiday = cfg.holiday_end != 0 && t.epoch_now < cfg.holiday_end;
					mday = (int'(t.week_day) + 6) % 7;
					if (cfg.legio_on && !heatup_active && mday == int'(cfg.legio_day) &&
							t.hour_of_day == cfg.legio_start_hour &&
							(!heatup_day_seen || last_heatup_day != t.year_day)) begin
						heatup_active   = 1;
						heatup_secs     = 0;
						last_heatup_day = t.year_day;
						heatup_day_seen = 1;
					end
					if (heatup_active) begin
						secs = heatup_secs + t.tick_seconds;
						heatup_secs = (secs > 65535) ? 65535 : secs;
						// success wins over timeout on the same tick
						if (tank >= $signed(cfg.legio_target)) begin
							heatup_active   = 0;
							timeout_latched = 0;
						end else if (heatup_secs > HEATUP_LIMIT) begin
							heatup_active   = 0;
							timeout_latched = 1;
						end
					end
					setp = heatup_active ? $signed(cfg.legio_target) : $signed(cfg.target_temp);
					want = charging;
					if (tank < setp - int'(cfg.hysteresis_band)) want = 1;
					if (tank >= setp) want = 0;
					if (!t.schedule_allows && !heatup_active) want = 0;
					if (holiday && !heatup_active) want = 0;
					if (t.source_valid && src < tank + int'(hwcc_pkg::SOURCE_MARGIN)) want = 0;
					charging = want;
				end
			end
			r.pump_on       = want;
			r.legio_running = heatup_active;
			r.sensor_fault  = fault_latched;
			r.legio_fail    = timeout_latched;
			return r;
		endfunction

		function void note_tick(hwcc_pkg::item_t t);
			expected_results.push_back(predict_charge(t));
		endfunction

		function void check_result(hwcc_pkg::result_t got);
			hwcc_pkg::result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result with nothing pending: %b", $realtime, got);
				return;
			end
			want = expected_results.pop_front();
			if (got.pump_on != want.pump_on || got.legio_running != want.legio_running ||
					got.sensor_fault != want.sensor_fault ||
					got.legio_fail != want.legio_fail) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch pump/running/fault/fail expected %b%b%b%b got %b%b%b%b",
						$realtime, want.pump_on, want.legio_running, want.sensor_fault,
						want.legio_fail, got.pump_on, got.legio_running, got.sensor_fault,
						got.legio_fail);
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	typedef enum int {SEG_RAMP, SEG_COLD, SEG_NOISE} seg_mode_t;

	logic               clk             = 1'b0;
	logic               arst_n          = 1'b0;
	logic               wr_en           = 1'b0;
	logic [hwcc_pkg::CFG_IDX_W-1:0]  wr_index = '0;
	logic [hwcc_pkg::CFG_DATA_W-1:0] wr_data  = '0;
	logic               in_valid        = 1'b0;
	logic               in_stall;
	logic signed [11:0] tank_temp       = '0;
	logic               tank_valid      = 1'b0;
	logic signed [11:0] source_temp     = '0;
	logic               source_valid    = 1'b0;
	logic [2:0]         week_day        = '0;
	logic [4:0]         hour_of_day     = '0;
	logic [8:0]         year_day        = '0;
	logic [31:0]        epoch_now       = '0;
	logic [7:0]         tick_seconds    = '0;
	logic               schedule_allows = 1'b0;
	logic               out_valid;
	logic               out_stall       = 1'b0;
	logic               pump_on;
	logic               legio_running;
	logic               sensor_fault;
	logic               legio_fail;

	charge_scoreboard sb;
	int               send_idle = 36;
	int               recv_idle = 70;
	int               hold_left = 0;

	// random tick generator state
	seg_mode_t        seg_mode  = SEG_NOISE;
	int               seg_left  = 0;
	int               gen_tank  = 0;
	logic [8:0]       gen_yday  = '0;
	logic [31:0]      gen_epoch = '0;

	hot_water_charge_controller #(
		.LEGIO_LIMIT_SECONDS(HEATUP_LIMIT)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.tank_temp       (tank_temp),
		.tank_valid      (tank_valid),
		.source_temp     (source_temp),
		.source_valid    (source_valid),
		.week_day        (week_day),
		.hour_of_day     (hour_of_day),
		.year_day        (year_day),
		.epoch_now       (epoch_now),
		.tick_seconds    (tick_seconds),
		.schedule_allows (schedule_allows),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pump_on         (pump_on),
		.legio_running   (legio_running),
		.sensor_fault    (sensor_fault),
		.legio_fail      (legio_fail)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: a hold-off request overrides the random stall
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(hwcc_pkg::result_t'({pump_on, legio_running, sensor_fault,
				legio_fail}));
	end

	function automatic logic signed [11:0] clamp12(int v);
		if (v > 2047) return 12'sd2047;
		if (v < -2048) return -12'sd2048;
		return 12'(v);
	endfunction

	task automatic send_tick(hwcc_pkg::item_t t);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		tank_temp       <= t.tank_temp;
		tank_valid      <= t.tank_valid;
		source_temp     <= t.source_temp;
		source_valid    <= t.source_valid;
		week_day        <= t.week_day;
		hour_of_day     <= t.hour_of_day;
		year_day        <= t.year_day;
		epoch_now       <= t.epoch_now;
		tick_seconds    <= t.tick_seconds;
		schedule_allows <= t.schedule_allows;
		// hold the payload until the transfer
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_tick(t);
	endtask

	task automatic send_fields(int tank, bit tv, int src, bit sv, int wd, int hr, int yd,
			logic [31:0] ep, int secs, bit sch);
		hwcc_pkg::item_t t;
		t.tank_temp       = clamp12(tank);
		t.tank_valid      = tv;
		t.source_temp     = clamp12(src);
		t.source_valid    = sv;
		t.week_day        = 3'(wd);
		t.hour_of_day     = 5'(hr);
		t.year_day        = 9'(yd);
		t.epoch_now       = ep;
		t.tick_seconds    = 8'(secs);
		t.schedule_allows = sch;
		send_tick(t);
	endtask

	task automatic drain_and_settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(hwcc_pkg::cfg_reg_t idx, logic [31:0] d);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= d;
		@(negedge clk);
		wr_en    <= 1'b0;
		sb.update_reg(idx, d);
	endtask

	// junk above each register's width must be ignored
	task automatic program_regs(hwcc_pkg::cfg_t c);
		logic [31:0] d;
		d = $urandom(); d[0] = c.block_enabled;
		cfg_write(hwcc_pkg::REG_BLOCK_ENABLED, d);
		d = $urandom(); d[11:0] = c.target_temp;
		cfg_write(hwcc_pkg::REG_TARGET_TEMP, d);
		d = $urandom(); d[8:0] = c.hysteresis_band;
		cfg_write(hwcc_pkg::REG_HYSTERESIS_BAND, d);
		d = $urandom(); d[0] = c.legio_on;
		cfg_write(hwcc_pkg::REG_LEGIO_ON, d);
		d = $urandom(); d[2:0] = c.legio_day;
		cfg_write(hwcc_pkg::REG_LEGIO_DAY, d);
		d = $urandom(); d[4:0] = c.legio_start_hour;
		cfg_write(hwcc_pkg::REG_LEGIO_START_HOUR, d);
		d = $urandom(); d[11:0] = c.legio_target;
		cfg_write(hwcc_pkg::REG_LEGIO_TARGET, d);
		cfg_write(hwcc_pkg::REG_HOLIDAY_END, c.holiday_end);
	endtask

	function automatic hwcc_pkg::cfg_t make_setting(int k);
		hwcc_pkg::cfg_t c;
		c.block_enabled    = 1'b1;
		c.target_temp      = 12'(int'($urandom_range(2000)) - 500);
		c.hysteresis_band  = 9'($urandom_range(500));
		c.legio_on         = 1'b1;
		c.legio_day        = 3'($urandom_range(6));
		c.legio_start_hour = 5'($urandom_range(23));
		c.legio_target     = 12'(int'($urandom_range(2000)) - 500);
		c.holiday_end      = ($urandom_range(1) != 0) ? $urandom() : 32'd0;
		case (k)
			0: begin
				c.target_temp = 12'sd500; c.hysteresis_band = 9'd50;
				c.legio_day = 3'd2; c.legio_start_hour = 5'd3;
				c.legio_target = 12'sd600; c.holiday_end = 32'd1000;
			end
			1: begin
				c.target_temp = -12'sd500; c.hysteresis_band = 9'd0;
				c.legio_day = 3'd6; c.legio_start_hour = 5'd23;
				c.legio_target = 12'sd1500; c.holiday_end = 32'd0;
			end
			2: begin
				c.target_temp = 12'sd1500; c.hysteresis_band = 9'd500;
				c.legio_day = 3'd0; c.legio_start_hour = 5'd0;
				c.legio_target = -12'sd500; c.holiday_end = 32'hFFFF_FFFF;
			end
			3: begin
				// a day code that monday_day can never return, so no heat-up starts
				c.target_temp = 12'sd550; c.hysteresis_band = 9'd30;
				c.legio_day = 3'd7; c.legio_start_hour = 5'd31;
				c.legio_target = 12'sd700; c.holiday_end = 32'd0;
			end
			4: c.block_enabled = 1'b0;
			6: begin
				c.target_temp = 12'sd450; c.hysteresis_band = 9'd40;
				c.legio_on = 1'b0; c.legio_day = 3'd3; c.legio_start_hour = 5'd5;
				c.legio_target = 12'sd650; c.holiday_end = 32'h8000_0000;
			end
			default: ;
		endcase
		return c;
	endfunction

	function automatic hwcc_pkg::item_t make_random_tick();
		hwcc_pkg::item_t t;
		hwcc_pkg::cfg_t  c;
		int              lo, hi, wd;
		c  = sb.cfg;
		lo = (($signed(c.target_temp) < $signed(c.legio_target)) ?
			$signed(c.target_temp) : $signed(c.legio_target)) - int'(c.hysteresis_band);
		hi = ($signed(c.target_temp) > $signed(c.legio_target)) ?
			$signed(c.target_temp) : $signed(c.legio_target);
		if (seg_left == 0) begin
			seg_mode = seg_mode_t'($urandom_range(2));
			seg_left = (seg_mode == SEG_COLD) ? 70 : int'($urandom_range(80, 40));
			// mostly a new day so the heat-up can start again
			if ($urandom_range(3) != 0)
				gen_yday = (gen_yday >= 9'd365) ? 9'd0 : gen_yday + 9'd1;
			gen_tank  = lo - int'($urandom_range(150));
			gen_epoch = ($urandom_range(1) != 0) ? c.holiday_end - $urandom_range(3000)
				: $urandom();
		end
		seg_left--;
		case (seg_mode)
			SEG_RAMP: begin
				gen_tank += int'($urandom_range(12));
				if (gen_tank > hi + 30) gen_tank = lo - int'($urandom_range(100));
			end
			SEG_COLD: gen_tank = $signed(c.legio_target) - 20 - int'($urandom_range(200));
			default:  gen_tank = $signed(12'($urandom()));
		endcase
		t.tank_temp    = clamp12(gen_tank);
		t.tank_valid   = ($urandom_range(99) >= 3);
		t.source_valid = ($urandom_range(99) >= 12);
		if (seg_mode == SEG_NOISE || $urandom_range(9) == 0)
			t.source_temp = 12'($urandom());
		else
			t.source_temp = clamp12(gen_tank + 30 + int'($urandom_range(200)));
		if ($urandom_range(1) != 0) begin
			wd = (int'(c.legio_day) + 1) % 7;
			if (c.legio_day == 3'd6 && $urandom_range(1) != 0) wd = 7;
			t.week_day    = 3'(wd);
			t.hour_of_day = c.legio_start_hour;
		end else begin
			t.week_day    = 3'($urandom());
			t.hour_of_day = ($urandom_range(7) == 0) ? 5'($urandom()) : 5'($urandom_range(23));
		end
		t.year_day = ($urandom_range(19) == 0) ? 9'($urandom()) : gen_yday;
		if (seg_mode == SEG_COLD)
			t.tick_seconds = 8'($urandom_range(255, 220));
		else
			t.tick_seconds = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom());
		gen_epoch += 32'(t.tick_seconds);
		t.epoch_now = ($urandom_range(19) == 0) ? $urandom() : gen_epoch;
		t.schedule_allows = ($urandom_range(3) != 0);
		return t;
	endfunction

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int k, n, count;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// block still disabled after reset: pump off, nothing latched
		send_fields(300, 0, 1500, 1, 1, 10, 100, 5000, 10, 1);
		send_fields(300, 1, 1500, 1, 3, 3, 100, 5000, 10, 1);
		drain_and_settle();
		program_regs(make_setting(0));

		send_fields(300, 0, 1500, 1, 1, 10, 100, 5000, 10, 1);    // sensor missing
		send_fields(300, 1, 1500, 1, 1, 10, 100, 5000, 10, 1);    // charge
		send_fields(300, 1, 1500, 1, 1, 10, 100, 999, 10, 1);     // holiday
		send_fields(300, 1, 1500, 1, 1, 10, 100, 1000, 10, 1);    // holiday just over
		send_fields(300, 1, 349, 1, 1, 10, 100, 5000, 10, 1);     // source 4.9 K warmer
		send_fields(300, 1, 350, 1, 1, 10, 100, 5000, 10, 1);     // source 5 K warmer
		send_fields(300, 1, -500, 0, 1, 10, 100, 5000, 10, 1);    // source absent
		send_fields(500, 1, 1500, 1, 1, 10, 100, 5000, 10, 1);    // setpoint reached
		send_fields(460, 1, 1500, 1, 1, 10, 100, 5000, 10, 1);    // inside band, hold off
		send_fields(449, 1, 1500, 1, 1, 10, 100, 5000, 10, 1);    // below band
		send_fields(470, 1, 1500, 1, 1, 10, 100, 5000, 10, 1);    // inside band, hold on
		send_fields(470, 1, 1500, 1, 1, 10, 100, 5000, 10, 0);    // schedule blocks
		send_fields(550, 1, 1500, 1, 3, 3, 100, 5000, 255, 0);    // heat-up starts
		send_fields(580, 1, 1500, 1, 3, 3, 100, 500, 255, 0);     // ignores holiday
		send_fields(600, 1, 1500, 1, 3, 3, 100, 5000, 255, 1);    // heat-up succeeds
		send_fields(550, 1, 1500, 1, 3, 3, 100, 5000, 255, 1);    // same day, no restart
		send_fields(550, 1, 1500, 1, 3, 3, 101, 5000, 255, 1);    // next day restarts
		send_fields(550, 0, 1500, 1, 3, 3, 101, 5000, 255, 1);    // fault keeps heat-up
		send_fields(560, 1, 1500, 1, 3, 3, 101, 5000, 0, 1);
		send_fields(-500, 1, 1500, 1, 6, 23, 365, 32'hFFFF_FFFF, 255, 0);
		send_fields(1500, 1, -500, 1, 0, 0, 0, 0, 0, 1);
		send_fields(-2048, 1, 2047, 1, 7, 31, 511, 0, 0, 1);
		send_fields(2047, 1, -2048, 1, 7, 31, 511, 32'hFFFF_FFFF, 255, 1);
		drain_and_settle();

		for (k = 1; k <= 6; k++) begin
			if (k <= 2) begin
				send_idle = 36; recv_idle = 70;
			end else if (k <= 4) begin
				send_idle = 70; recv_idle = 36;
			end else begin
				send_idle = 0; recv_idle = 0;
			end
			program_regs(make_setting(k));
			seg_left = 0;
			count = (k == 4) ? 100 : (k == 5) ? 450 : 320;
			for (n = 0; n < count; n++) begin
				// long receiver hold-off while ticks keep coming
				if (n == 120 && (k == 2 || k == 5)) hold_left = 90;
				send_tick(make_random_tick());
			end
			drain_and_settle();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### filelist.f
sv/hwcc_pkg.sv
sv/hwcc_cfg_regs.sv
sv/hwcc_decide.sv
sv/hot_water_charge_controller.sv
test/hot_water_charge_controller_test.sv
